/* sv/srp_pkg.sv */
package srp_pkg;

   // Widths of the word fields.
   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned KIND_WIDTH   = 3;
   localparam int unsigned CODE_WIDTH   = 10;
   localparam int unsigned LEN_WIDTH    = 16;
   localparam int unsigned POS_WIDTH    = 3;

   // Default width of the saturating byte counter.
   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

   // Most result words that one input byte can cause.
   localparam int unsigned MAX_RESULTS = 3;

   // Result kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_NONE       = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_BYTE       = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_DONE       = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_FORMAT     = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_CODE       = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_INCOMPLETE = 3'd5;

   // Characters the parser looks for.
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE   = 8'h39;

   // Positions within a line: three digits, then the separator, then text.
   localparam logic [POS_WIDTH-1:0] POS_FIRST_DIGIT = 3'd0;
   localparam logic [POS_WIDTH-1:0] POS_SEPARATOR   = 3'd3;
   localparam logic [POS_WIDTH-1:0] POS_TEXT        = 3'd4;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] byte_value;
      logic                  end_of_data;
   } srp_req_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic [BYTE_WIDTH-1:0] message_byte;
      logic [CODE_WIDTH-1:0] reply_code;
      logic [LEN_WIDTH-1:0]  reply_length;
      logic                  last_of_item;
   } srp_rsp_type;

   typedef srp_rsp_type [MAX_RESULTS-1:0] srp_bundle_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0]  line_position;
      logic                  first_line;
      logic                  is_final_line;
      logic [CODE_WIDTH-1:0] saved_code;
      logic [CODE_WIDTH-1:0] current_code;
      logic                  held_carriage_return;
      logic                  error_hold;
   } srp_state_type;

   localparam srp_state_type STATE_RESET = '{
      line_position:        POS_FIRST_DIGIT,
      first_line:           1'b1,
      is_final_line:        1'b0,
      saved_code:           '0,
      current_code:         '0,
      held_carriage_return: 1'b0,
      error_hold:           1'b0
   };

   // Status the result queue reports to the top level.
   typedef struct packed {
      logic word_valid;
      logic has_room;
   } srp_queue_status_type;

   function automatic srp_rsp_type make_result(
      input logic [KIND_WIDTH-1:0] kind,
      input logic [BYTE_WIDTH-1:0] message_byte,
      input logic [CODE_WIDTH-1:0] reply_code,
      input logic [LEN_WIDTH-1:0]  reply_length
   );
      srp_rsp_type r;
      r.kind         = kind;
      r.message_byte = message_byte;
      r.reply_code   = reply_code;
      r.reply_length = reply_length;
      r.last_of_item = 1'b0;
      return r;
   endfunction

endpackage

/* sv/srp_step.sv */
// Next-state and result logic for one received byte.
module srp_step #(
   parameter int unsigned COUNT_WIDTH = srp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  srp_pkg::srp_state_type   state_cur,
   input  logic [COUNT_WIDTH-1:0]   count_cur,
   input  srp_pkg::srp_req_type     req_word,
   output srp_pkg::srp_state_type   state_next,
   output logic [COUNT_WIDTH-1:0]   count_next,
   output srp_pkg::srp_bundle_type  results,
   output logic [1:0]               result_count
);

   logic                                 err;
   logic                                 done;
   logic [1:0]                           n;
   logic [srp_pkg::CODE_WIDTH-1:0]       base;
   logic [srp_pkg::BYTE_WIDTH-1:0]       b;
   logic                                 eod;

   always_comb begin
      state_next = state_cur;
      count_next = count_cur;
      results    = '0;
      n          = 2'd0;
      done       = 1'b0;
      err        = state_cur.error_hold;
      base       = '0;
      b          = req_word.byte_value;
      eod        = req_word.end_of_data;

      if (state_cur.error_hold) begin
         if (eod) begin
            state_next = srp_pkg::STATE_RESET;
            count_next = '0;
         end
      end else begin
         if (count_cur != {COUNT_WIDTH{1'b1}}) begin
            count_next = count_cur + COUNT_WIDTH'(1);
         end

         if (state_cur.line_position < srp_pkg::POS_SEPARATOR) begin
            if (b inside {[srp_pkg::CHAR_ZERO:srp_pkg::CHAR_NINE]}) begin
               base = (state_cur.line_position == srp_pkg::POS_FIRST_DIGIT) ?
                      '0 : state_cur.current_code;
               state_next.current_code = (base << 3) + (base << 1)
                                       + srp_pkg::CODE_WIDTH'(b - srp_pkg::CHAR_ZERO);
               state_next.line_position = state_cur.line_position + 3'd1;
            end else begin
               results[n] = srp_pkg::make_result(srp_pkg::KIND_FORMAT, '0, '0, '0);
               n   = n + 2'd1;
               err = 1'b1;
            end
         end else if (state_cur.line_position == srp_pkg::POS_SEPARATOR) begin
            if (b == srp_pkg::CHAR_SPACE || b == srp_pkg::CHAR_HYPHEN) begin
               if (state_cur.first_line) begin
                  state_next.saved_code = state_cur.current_code;
               end else if (state_cur.current_code != state_cur.saved_code) begin
                  results[n] = srp_pkg::make_result(srp_pkg::KIND_CODE, '0, '0, '0);
                  n   = n + 2'd1;
                  err = 1'b1;
               end
               if (!err) begin
                  state_next.is_final_line = (b == srp_pkg::CHAR_SPACE);
                  state_next.line_position = srp_pkg::POS_TEXT;
               end
            end else begin
               results[n] = srp_pkg::make_result(srp_pkg::KIND_FORMAT, '0, '0, '0);
               n   = n + 2'd1;
               err = 1'b1;
            end
         end else begin
            if (state_cur.held_carriage_return && b == srp_pkg::CHAR_LF) begin
               state_next.held_carriage_return = 1'b0;
               if (state_cur.is_final_line) begin
                  results[n] = srp_pkg::make_result(srp_pkg::KIND_DONE, '0,
                                  state_cur.saved_code,
                                  srp_pkg::LEN_WIDTH'(count_next));
                  n          = n + 2'd1;
                  state_next = srp_pkg::STATE_RESET;
                  count_next = '0;
                  done       = 1'b1;
               end else begin
                  results[n] = srp_pkg::make_result(srp_pkg::KIND_BYTE,
                                  srp_pkg::CHAR_LF, '0, '0);
                  n = n + 2'd1;
                  state_next.line_position = srp_pkg::POS_FIRST_DIGIT;
                  state_next.first_line    = 1'b0;
               end
            end else begin
               // A held CR not followed by LF is plain text after all.
               if (state_cur.held_carriage_return) begin
                  results[n] = srp_pkg::make_result(srp_pkg::KIND_BYTE,
                                  srp_pkg::CHAR_CR, '0, '0);
                  n = n + 2'd1;
               end
               if (b == srp_pkg::CHAR_CR) begin
                  state_next.held_carriage_return = 1'b1;
               end else begin
                  state_next.held_carriage_return = 1'b0;
                  results[n] = srp_pkg::make_result(srp_pkg::KIND_BYTE, b, '0, '0);
                  n = n + 2'd1;
               end
            end
         end

         if (eod) begin
            if (!err && !done) begin
               results[n] = srp_pkg::make_result(srp_pkg::KIND_INCOMPLETE, '0, '0, '0);
               n = n + 2'd1;
            end
            state_next = srp_pkg::STATE_RESET;
            count_next = '0;
         end else if (!done) begin
            state_next.error_hold = err;
         end
      end

      if (n == 2'd0) begin
         results[0] = srp_pkg::make_result(srp_pkg::KIND_NONE, '0, '0, '0);
         n = 2'd1;
      end
      results[n - 2'd1].last_of_item = 1'b1;
   end

   assign result_count = n;

endmodule

/* sv/srp_out_queue.sv */
// Four-entry result queue; the head entry drives the output word.
module srp_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  srp_pkg::srp_bundle_type       results,
   input  logic [1:0]                    result_count,
   input  logic                          rsp_stall,
   output srp_pkg::srp_rsp_type          rsp_word,
   output srp_pkg::srp_queue_status_type status
);

   localparam int unsigned DEPTH = 4;

   srp_pkg::srp_rsp_type slot_ff [DEPTH];
   srp_pkg::srp_rsp_type slot_in [DEPTH];
   logic [2:0]           count_ff;
   logic [2:0]           count_in;
   logic                 pop;
   logic [2:0]           live;
   logic [2:0]           rel;

   assign pop  = (count_ff != 3'd0) && !rsp_stall;
   assign live = count_ff - {2'b00, pop};

   always_comb begin
      rel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && i < DEPTH - 1) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         rel = 3'(i) - live;
         if (push && 3'(i) >= live && rel < {1'b0, result_count}) begin
            slot_in[i] = results[rel[1:0]];
         end
      end
   end

   assign count_in = live + (push ? {1'b0, result_count} : 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign rsp_word          = slot_ff[0];
   assign status.word_valid = (count_ff != 3'd0);
   // Room for a full set of results even if the head word is not taken.
   assign status.has_room   = (count_ff <= 3'd1);

endmodule

/* sv/smtp_reply_parser_core.sv */
// Streaming parser for multi-line SMTP replies.
//
// The req channel takes one received byte per word, with end_of_data marking
// the last byte currently available. The rsp channel returns one to three words
// per byte: a message text byte, reply done with the code and byte count,
// invalid format, invalid code, incomplete, or a nothing word. The last word
// caused by a byte has last_of_item set.
//
// A byte is parsed in the cycle it is accepted and its words are written into
// a four-entry result queue, whose head register drives the rsp channel. While
// the receiver does not stall, a byte that yields a single word can follow
// every cycle, so the sustained rate is one byte per cycle. A byte that yields
// two or three words holds off the next byte while the single rsp port drains
// the queue one word per cycle, as long as the receiver takes them.
//
// req_stall is high whenever more than one word waits in the queue, so it comes
// straight from a register and never from rsp_stall. When the receiver stalls,
// the head word holds and the queue fills until req_stall rises.
// Synchronous reset returns the parser to the start of a reply and empties the
// queue.
module smtp_reply_parser_core #(
   parameter int unsigned COUNT_WIDTH = srp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  srp_pkg::srp_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output srp_pkg::srp_rsp_type rsp_word
);

   // Parser state: line position, code tracking, held CR and error hold.
   srp_pkg::srp_state_type        state_ff;
   srp_pkg::srp_state_type        state_in;
   // Saturating count of bytes consumed by the current reply.
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic [COUNT_WIDTH-1:0]        count_in;
   srp_pkg::srp_state_type        state_next;
   logic [COUNT_WIDTH-1:0]        count_next;
   srp_pkg::srp_bundle_type       results;
   logic [1:0]                    result_count;
   srp_pkg::srp_queue_status_type queue_status;
   logic                          accept;

   assign req_stall = !queue_status.has_room;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = queue_status.word_valid;

   srp_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .state_cur    (state_ff),
      .count_cur    (count_ff),
      .req_word     (req_word),
      .state_next   (state_next),
      .count_next   (count_next),
      .results      (results),
      .result_count (result_count)
   );

   // State only advances when a word is actually taken from the req channel.
   assign state_in = accept ? state_next : state_ff;
   assign count_in = accept ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srp_pkg::STATE_RESET;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   srp_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (accept),
      .results      (results),
      .result_count (result_count),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .status       (queue_status)
   );

   // The queue is empty right after reset.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Reply done always closes the words of its byte.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == srp_pkg::KIND_DONE |-> rsp_word.last_of_item)
      else $error("reply done word without last_of_item");

   // Once an error is flagged, it is held until a byte with end_of_data.
   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_hold && accept && !req_word.end_of_data |=> state_ff.error_hold)
      else $error("error hold dropped before end of data");

   // Message text words carry no code and no length.
   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == srp_pkg::KIND_BYTE
      |-> rsp_word.reply_code == '0 && rsp_word.reply_length == '0)
      else $error("message byte word with code or length");

endmodule

/* sim/srp_reply_monitor.sv */
`timescale 1ns / 1ps

// Watches both channels of the reply parser. It keeps its own copy of the
// parse state, works out the words every accepted byte must produce, and
// compares each returned word with the oldest one still owed.
module srp_reply_monitor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  srp_pkg::srp_req_type req_word,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  srp_pkg::srp_rsp_type rsp_word,
   output int unsigned          mismatch_count,
   output int unsigned          words_awaited
);

   localparam longint unsigned COUNT_MAX =
      (64'd1 << srp_pkg::COUNT_WIDTH_DEFAULT) - 64'd1;

   // Parse state of the current reply.
   logic [srp_pkg::POS_WIDTH-1:0]  line_pos;
   logic                           on_first_line;
   logic                           on_final_line;
   logic [srp_pkg::CODE_WIDTH-1:0] first_code;
   logic [srp_pkg::CODE_WIDTH-1:0] code_so_far;
   logic                           cr_pending;
   logic                           in_error;
   longint unsigned                consumed;

   srp_pkg::srp_rsp_type byte_words[$];
   srp_pkg::srp_rsp_type owed_words[$];

   task automatic report_mismatch(input string what);
      $display("%0t ns: reply word mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic restart_reply();
      line_pos      = srp_pkg::POS_FIRST_DIGIT;
      on_first_line = 1'b1;
      on_final_line = 1'b0;
      first_code    = '0;
      code_so_far   = '0;
      cr_pending    = 1'b0;
      in_error      = 1'b0;
      consumed      = 0;
   endtask

   task automatic emit(input logic [srp_pkg::KIND_WIDTH-1:0] kind,
                       input logic [srp_pkg::BYTE_WIDTH-1:0] text,
                       input logic [srp_pkg::CODE_WIDTH-1:0] code,
                       input logic [srp_pkg::LEN_WIDTH-1:0]  len);
      srp_pkg::srp_rsp_type w;
      w.kind         = kind;
      w.message_byte = text;
      w.reply_code   = code;
      w.reply_length = len;
      w.last_of_item = 1'b0;
      if (byte_words.size() < srp_pkg::MAX_RESULTS) byte_words = {byte_words, w};
   endtask

   // A CR in the text is held until the next byte shows whether the line ends.
   task automatic take_text(input logic [srp_pkg::BYTE_WIDTH-1:0] value);
      if (value == srp_pkg::CHAR_CR) cr_pending = 1'b1;
      else emit(srp_pkg::KIND_BYTE, value, '0, '0);
   endtask

   task automatic flag_error(input logic [srp_pkg::KIND_WIDTH-1:0] kind);
      emit(kind, '0, '0, '0);
      in_error = 1'b1;
   endtask

   task automatic parse_reply_byte(input logic [srp_pkg::BYTE_WIDTH-1:0] value,
                                   input logic eod);
      logic                 finished;
      srp_pkg::srp_rsp_type w;
      finished = 1'b0;
      byte_words.delete();
      if (in_error) begin
         if (eod) restart_reply();
      end else begin
         if (consumed < COUNT_MAX) consumed++;
         if (line_pos < srp_pkg::POS_SEPARATOR) begin
            if (value >= srp_pkg::CHAR_ZERO && value <= srp_pkg::CHAR_NINE) begin
               code_so_far = srp_pkg::CODE_WIDTH'(
                  ((line_pos == srp_pkg::POS_FIRST_DIGIT) ? '0 : code_so_far) * 10
                  + (value - srp_pkg::CHAR_ZERO));
               line_pos++;
            end else begin
               flag_error(srp_pkg::KIND_FORMAT);
            end
         end else if (line_pos == srp_pkg::POS_SEPARATOR) begin
            if (value == srp_pkg::CHAR_SPACE || value == srp_pkg::CHAR_HYPHEN) begin
               if (on_first_line) first_code = code_so_far;
               else if (code_so_far != first_code) flag_error(srp_pkg::KIND_CODE);
               if (!in_error) begin
                  on_final_line = (value == srp_pkg::CHAR_SPACE);
                  line_pos      = srp_pkg::POS_TEXT;
               end
            end else begin
               flag_error(srp_pkg::KIND_FORMAT);
            end
         end else if (cr_pending) begin
            cr_pending = 1'b0;
            if (value == srp_pkg::CHAR_LF) begin
               if (on_final_line) begin
                  emit(srp_pkg::KIND_DONE, '0, first_code,
                       consumed[srp_pkg::LEN_WIDTH-1:0]);
                  restart_reply();
                  finished = 1'b1;
               end else begin
                  emit(srp_pkg::KIND_BYTE, srp_pkg::CHAR_LF, '0, '0);
                  line_pos      = srp_pkg::POS_FIRST_DIGIT;
                  on_first_line = 1'b0;
               end
            end else begin
               emit(srp_pkg::KIND_BYTE, srp_pkg::CHAR_CR, '0, '0);
               take_text(value);
            end
         end else begin
            take_text(value);
         end
         if (eod) begin
            if (in_error) begin
               restart_reply();
            end else if (!finished) begin
               emit(srp_pkg::KIND_INCOMPLETE, '0, '0, '0);
               restart_reply();
            end
         end
      end
      if (byte_words.size() == 0) emit(srp_pkg::KIND_NONE, '0, '0, '0);
      foreach (byte_words[i]) begin
         w = byte_words[i];
         w.last_of_item = (i == byte_words.size() - 1);
         owed_words = {owed_words, w};
      end
   endtask

   always @(posedge clock) begin
      srp_pkg::srp_rsp_type want;
      if (reset) begin
         restart_reply();
         owed_words.delete();
      end else begin
         // The returned word is checked first: it can never belong to a byte
         // taken at this same edge.
         if (rsp_valid && !rsp_stall) begin
            if (owed_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word kind %0d", rsp_word.kind));
            end else begin
               want = owed_words.pop_front();
               if (rsp_word.kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", rsp_word.kind, want.kind));
               if (rsp_word.message_byte !== want.message_byte)
                  report_mismatch($sformatf("message_byte %h, want %h",
                                            rsp_word.message_byte, want.message_byte));
               if (rsp_word.reply_code !== want.reply_code)
                  report_mismatch($sformatf("reply_code %0d, want %0d",
                                            rsp_word.reply_code, want.reply_code));
               if (rsp_word.reply_length !== want.reply_length)
                  report_mismatch($sformatf("reply_length %0d, want %0d",
                                            rsp_word.reply_length, want.reply_length));
               if (rsp_word.last_of_item !== want.last_of_item)
                  report_mismatch($sformatf("last_of_item %b, want %b",
                                            rsp_word.last_of_item, want.last_of_item));
            end
         end
         if (req_valid && !req_stall)
            parse_reply_byte(req_word.byte_value, req_word.end_of_data);
      end
      words_awaited = owed_words.size();
   end

endmodule

/* sim/tb_smtp_reply_parser_core.sv */
`timescale 1ns / 1ps

// Top of the reply parser bench. This module only makes stimulus and gives
// the verdict; all checking happens in the reply monitor beside the block.
module tb_smtp_reply_parser_core;

   // Generous bound on the whole run, far above the slowest correct run.
   localparam int unsigned CYCLE_LIMIT  = 200000;
   // Length of the single long receiver hold-off that backs the block up.
   localparam int unsigned LONG_HOLD    = 200;
   // Words sent before the long hold-off starts.
   localparam int unsigned HOLD_AFTER   = 40;
   // Size of the planned byte stream: directed part plus random replies.
   localparam int unsigned PLAN_TARGET  = 270;
   // Quiet cycles after the last owed word, to catch stray extra words.
   localparam int unsigned DRAIN_CYCLES = 20;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   srp_pkg::srp_req_type req_word  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   srp_pkg::srp_rsp_type rsp_word;

   int unsigned mismatch_count;
   int unsigned words_awaited;
   int unsigned words_sent = 0;
   int unsigned cycle_count = 0;

   // Every byte word to send, in order.
   srp_pkg::srp_req_type byte_plan[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   smtp_reply_parser_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   srp_reply_monitor reply_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .words_awaited  (words_awaited)
   );

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic plan_byte(input logic [srp_pkg::BYTE_WIDTH-1:0] value, input logic eod);
      srp_pkg::srp_req_type w;
      w.byte_value  = value;
      w.end_of_data = eod;
      byte_plan = {byte_plan, w};
   endtask

   task automatic plan_text(input string s);
      for (int i = 0; i < s.len(); i++) plan_byte(s[i], 1'b0);
   endtask

   // One random reply. Most are well formed with random text so that the
   // parser gets through its line, join and done logic; the rest are noise,
   // a wrong code on the last line, data cut short, or one corrupted byte.
   task automatic plan_random_reply();
      logic [srp_pkg::BYTE_WIDTH-1:0] seq[$];
      logic [srp_pkg::BYTE_WIDTH-1:0] v;
      int                             style;
      int                             code;
      int                             line_code;
      int                             lines;
      int                             n_text;
      int                             cut;
      style = $urandom_range(0, 9);
      if (style == 0) begin
         n_text = $urandom_range(1, 6);
         for (int i = 0; i < n_text; i++)
            plan_byte(8'($urandom_range(0, 255)), i == n_text - 1);
      end else begin
         code  = $urandom_range(0, 999);
         lines = $urandom_range(1, 3);
         for (int ln = 0; ln < lines; ln++) begin
            line_code = code;
            if (style == 1 && ln == lines - 1 && lines > 1)
               line_code = (code + $urandom_range(1, 999)) % 1000;
            seq = {seq, srp_pkg::CHAR_ZERO + 8'(line_code / 100)};
            seq = {seq, srp_pkg::CHAR_ZERO + 8'((line_code / 10) % 10)};
            seq = {seq, srp_pkg::CHAR_ZERO + 8'(line_code % 10)};
            seq = {seq, (ln == lines - 1) ? srp_pkg::CHAR_SPACE : srp_pkg::CHAR_HYPHEN};
            n_text = $urandom_range(0, 6);
            for (int t = 0; t < n_text; t++) begin
               case ($urandom_range(0, 11))
                  0: begin
                     seq = {seq, srp_pkg::CHAR_LF};
                  end
                  1: begin
                     // A lone CR, followed by a byte that does not end the line.
                     seq = {seq, srp_pkg::CHAR_CR};
                     v = 8'($urandom_range(0, 255));
                     if (v == srp_pkg::CHAR_CR || v == srp_pkg::CHAR_LF) v = srp_pkg::CHAR_HYPHEN;
                     seq = {seq, v};
                  end
                  default: begin
                     v = 8'($urandom_range(0, 255));
                     if (v == srp_pkg::CHAR_CR) v = srp_pkg::CHAR_SPACE;
                     seq = {seq, v};
                  end
               endcase
            end
            seq = {seq, srp_pkg::CHAR_CR};
            seq = {seq, srp_pkg::CHAR_LF};
         end
         if (style == 2) begin
            cut = $urandom_range(1, seq.size() - 1);
            while (seq.size() > cut) v = seq.pop_back();
            for (int i = 0; i < seq.size(); i++) plan_byte(seq[i], i == seq.size() - 1);
         end else begin
            if (style == 3) seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
            for (int i = 0; i < seq.size(); i++)
               plan_byte(seq[i], style >= 4 && i == seq.size() - 1 && $urandom_range(0, 1) == 1);
            // Broken replies are closed by end of data so the parser resyncs.
            if (style == 1 || style == 3) plan_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      end
   endtask

   // Sender: builds the byte plan, then offers it in bursts of random length
   // separated by random gaps. Each word is held until it is taken.
   initial begin
      int burst;
      int gap;

      // Continuation line whose only text is a bare LF, then a final line
      // where a CR is released by a second CR that then ends the line.
      plan_text("900-");
      plan_byte(srp_pkg::CHAR_LF, 1'b0);
      plan_byte(srp_pkg::CHAR_CR, 1'b0);
      plan_byte(srp_pkg::CHAR_LF, 1'b0);
      plan_text("900 ");
      plan_byte(srp_pkg::CHAR_CR, 1'b0);
      plan_byte(srp_pkg::CHAR_CR, 1'b0);
      plan_byte(srp_pkg::CHAR_LF, 1'b0);
      // A CR where the separator belongs, on the last byte of the data.
      plan_text("123");
      plan_byte(srp_pkg::CHAR_CR, 1'b1);
      // The second line carries a different code; the rest is ignored up to and
      // including the end of data.
      plan_text("100-");
      plan_byte(srp_pkg::CHAR_CR, 1'b0);
      plan_byte(srp_pkg::CHAR_LF, 1'b0);
      plan_text("101 ");
      plan_byte(8'hFF, 1'b1);
      // A letter where a digit belongs, then data ending after one digit.
      plan_byte("x", 1'b1);
      plan_byte("7", 1'b1);

      while (byte_plan.size() < PLAN_TARGET) plan_random_reply();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      burst = 0;
      while (byte_plan.size() > 0) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         @(negedge clock);
         req_valid <= 1'b1;
         req_word  <= byte_plan.pop_front();
         do @(posedge clock); while (req_stall);
         words_sent++;
         burst--;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Wait for every owed word, then a quiet drain period to catch strays.
      while (words_awaited != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver: stalls on a pattern that it picks anew at random, with
   // stretches of no stall at all. Once, early in the random part, it
   // holds off for a long stretch while the sender keeps offering bytes, so
   // the result queue fills and req_stall must rise.
   initial begin
      bit long_hold_done;
      int mode;
      int span;
      long_hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && words_sent >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         for (int i = 0; i < span; i++) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= (i % 3 == 2);
            endcase
            @(negedge clock);
         end
      end
   end

endmodule
